### rtl/core/tes_pkg.sv
// Package for the timed event scheduler: shared types and constants.
// Depends on nothing; tes_cell, the top level and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none
package tes_pkg;

    // Slot indexes travel internally at 8 bits, wider than the 4-bit slot fields of the ports.
    localparam int IDX_W = 8;

    localparam logic [1:0] KIND_ONESHOT  = 2'd0;
    localparam logic [1:0] KIND_REPEATED = 2'd1;
    localparam logic [1:0] KIND_INTERVAL = 2'd2;
    localparam logic [1:0] KIND_INVALID  = 2'd3;

    localparam logic FUNC_ARM  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Command broadcast to every cell.
    typedef struct packed {
        logic             arm;
        logic             fire;
        logic [IDX_W-1:0] idx;
        logic [1:0]       kind;
        logic [31:0]      start_time;
        logic [31:0]      delay;
        logic [31:0]      period;
        logic [15:0]      repeat_count;
    } t_cell_cmd;

    // Best candidate handed along the chain.
    typedef struct packed {
        logic             valid;
        logic [31:0]      due;
        logic [IDX_W-1:0] idx;
    } t_tok;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/tes_if.sv
// Handshake interfaces for the input and result channels of the scheduler.
// Depends on nothing but the language.
`timescale 1ns / 1ps
`default_nettype none
interface tes_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [3:0]  slot;
    logic [1:0]  kind;
    logic [31:0] start_time;
    logic [31:0] delay;
    logic [31:0] period;
    logic [15:0] repeat_count;
    logic [31:0] now;

    modport source (output valid, func, slot, kind, start_time, delay, period,
                    repeat_count, now, input ready);
    modport sink   (input valid, func, slot, kind, start_time, delay, period,
                    repeat_count, now, output ready);
endinterface

interface tes_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  fired_slot;
    logic [31:0] due_time;
    logic [31:0] fire_time;
    logic        more_pending;
    logic        last;

    modport source (output valid, fired_slot, due_time, fire_time, more_pending, last,
                    input ready);
    modport sink   (input valid, fired_slot, due_time, fire_time, more_pending, last,
                    output ready);
endinterface
`default_nettype wire

### rtl/core/tes_cell.sv
// One event slot of the scheduler chain: holds the slot state and passes on
// the earlier of its own due event and the candidate from its left neighbor.
// Depends on tes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tes_cell #(
    parameter int IDX = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tes_pkg::t_cell_cmd i_cmd,
    input  wire logic [31:0]        i_now,
    input  wire tes_pkg::t_tok      i_tok,
    output tes_pkg::t_tok           o_tok
);
    import tes_pkg::*;

    logic        r_armed;
    logic [1:0]  r_kind;
    logic [31:0] r_due;
    logic [31:0] r_period;
    logic [15:0] r_rem;
    t_tok        r_tok;
    logic        mine;
    logic        self_due;

    assign mine     = (i_cmd.idx == IDX_W'(IDX));
    assign self_due = r_armed && (r_due <= i_now);

    // Control state: armed flag and kind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_kind  <= KIND_ONESHOT;
        end else if (mine && i_cmd.arm) begin
            r_kind  <= i_cmd.kind;
            r_armed <= !(i_cmd.kind == KIND_REPEATED && i_cmd.repeat_count == 16'd0);
        end else if (mine && i_cmd.fire) begin
            case (r_kind)
                KIND_ONESHOT:  r_armed <= 1'b0;
                KIND_REPEATED: if (r_rem <= 16'd1) r_armed <= 1'b0;
                default:       r_armed <= r_armed;
            endcase
        end
    end

    // Payload: due time, period and remaining count.
    always_ff @(posedge i_clk) begin
        if (mine && i_cmd.arm) begin
            r_due    <= sat_add(i_cmd.start_time, i_cmd.delay);
            r_period <= i_cmd.period;
            r_rem    <= i_cmd.repeat_count;
        end else if (mine && i_cmd.fire) begin
            case (r_kind)
                KIND_REPEATED: begin
                    if (r_rem <= 16'd1) begin
                        r_rem <= 16'd0;
                    end else begin
                        r_rem <= r_rem - 16'd1;
                        r_due <= sat_add(r_due, r_period);
                    end
                end
                KIND_INTERVAL: r_due <= sat_add(r_due, r_period);
                default:       r_due <= r_due;
            endcase
        end
    end

    // Pass the earlier candidate on; ties keep the lower slot from the left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (self_due && (!i_tok.valid || r_due < i_tok.due)) begin
            r_tok.valid <= 1'b1;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (self_due && (!i_tok.valid || r_due < i_tok.due)) begin
            r_tok.due <= r_due;
            r_tok.idx <= IDX_W'(IDX);
        end else begin
            r_tok.due <= i_tok.due;
            r_tok.idx <= i_tok.idx;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

### rtl/core/timed_event_scheduler_top.sv
// Top level of the timed event scheduler: sequencer, result register and
// the chain of slot cells. Depends on tes_pkg, tes_if and tes_cell.
//
// Usage: items enter on i_in. An arm beat (func 0) with a valid kind and an
// in-range slot loads that slot and gives no result. A tick beat (func 1)
// fires every due event in order of earliest due time, lower slot first on
// ties, one result beat per firing on o_out, with last set on the final one
// and more_pending set there when the cap of MAX_FIRE firings left due
// events behind. Each firing needs one pass of the candidate through the
// cell chain; a tick with nothing due gives no result. The first result
// appears after the second chain pass, since a result is released only once
// the next pass shows whether it is the last.
// i_in is ready only while no tick is at work. A stalled receiver holds
// the result register and the sequencer waits with the chain unchanged.
// Reset frees every slot and drops all pending results.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_scheduler_top #(
    parameter int SLOTS    = 16,
    parameter int MAX_FIRE = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tes_in_if.sink    i_in,
    tes_out_if.source o_out
);
    import tes_pkg::*;

    localparam int SCAN_W = $clog2(SLOTS + 1);
    localparam int FIRE_W = $clog2(MAX_FIRE + 1);

    t_state            r_state, n_state;
    logic [SCAN_W-1:0] r_scan, n_scan;
    logic [FIRE_W-1:0] r_fired, n_fired;
    logic [31:0]       r_now;
    logic              r_held_valid, n_held_valid;
    logic [IDX_W-1:0]  r_held_idx;
    logic [31:0]       r_held_due;
    logic              r_out_valid;
    logic [3:0]        r_out_slot;
    logic [31:0]       r_out_due;
    logic [31:0]       r_out_time;
    logic              r_out_more;
    logic              r_out_last;
    logic              push, push_last, push_more, take_tok;
    logic              in_accept, out_free;
    t_cell_cmd         cmd;
    t_tok              tok [SLOTS+1];

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Sequencer: next state, firing decision and cell commands.
    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_fired      = r_fired;
        n_held_valid = r_held_valid;
        push         = 1'b0;
        push_last    = 1'b0;
        push_more    = 1'b0;
        take_tok     = 1'b0;
        cmd          = '0;
        cmd.idx          = {{(IDX_W-4){1'b0}}, i_in.slot};
        cmd.kind         = i_in.kind;
        cmd.start_time   = i_in.start_time;
        cmd.delay        = i_in.delay;
        cmd.period       = i_in.period;
        cmd.repeat_count = i_in.repeat_count;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && i_in.func == FUNC_TICK) begin
                    n_state      = ST_SCAN;
                    n_scan       = SCAN_W'(SLOTS);
                    n_fired      = '0;
                    n_held_valid = 1'b0;
                end else if (in_accept && i_in.kind != KIND_INVALID
                             && {5'd0, i_in.slot} < 9'(SLOTS)) begin
                    cmd.arm = 1'b1;
                end
            end
            ST_SCAN: begin
                if (r_scan != '0) begin
                    n_scan = r_scan - SCAN_W'(1);
                end else if (!r_held_valid || out_free) begin
                    if (tok[SLOTS].valid && r_fired != FIRE_W'(MAX_FIRE)) begin
                        push         = r_held_valid;
                        take_tok     = 1'b1;
                        n_held_valid = 1'b1;
                        n_fired      = r_fired + FIRE_W'(1);
                        n_scan       = SCAN_W'(SLOTS);
                        cmd.fire     = 1'b1;
                        cmd.idx      = tok[SLOTS].idx;
                    end else begin
                        push         = r_held_valid;
                        push_last    = 1'b1;
                        push_more    = tok[SLOTS].valid;
                        n_held_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan       <= '0;
            r_fired      <= '0;
            r_held_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan       <= n_scan;
            r_fired      <= n_fired;
            r_held_valid <= n_held_valid;
        end
    end

    // Tick time and the firing held back until its last flag is known.
    always_ff @(posedge i_clk) begin
        if (in_accept && i_in.func == FUNC_TICK) begin
            r_now <= i_in.now;
        end
        if (take_tok) begin
            r_held_idx <= tok[SLOTS].idx;
            r_held_due <= tok[SLOTS].due;
        end
    end

    // Result register toward the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_slot <= r_held_idx[3:0];
            r_out_due  <= r_held_due;
            r_out_time <= r_now;
            r_out_more <= push_more;
            r_out_last <= push_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.fired_slot   = r_out_slot;
    assign o_out.due_time     = r_out_due;
    assign o_out.fire_time    = r_out_time;
    assign o_out.more_pending = r_out_more;
    assign o_out.last         = r_out_last;

    // Chain of slot cells; the candidate enters empty on the left.
    assign tok[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        tes_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_now   (r_now),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the timed event scheduler: drives arm and tick beats, predicts
// every firing in a behavioral copy of the slot table and checks each result.
// Depends on tes_pkg, tes_if and timed_event_scheduler_top.
`timescale 1ns / 1ps
module testbench;
    import tes_pkg::*;

    localparam int NSLOT   = 16;
    localparam int FIRECAP = 64;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [3:0]  fired_slot;
        logic [31:0] due_time;
        logic [31:0] fire_time;
        logic        more_pending;
        logic        last;
    } t_firing;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tes_in_if  in_ch ();
    tes_out_if out_ch ();

    timed_event_scheduler_top #(.SLOTS(NSLOT), .MAX_FIRE(FIRECAP)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow slot table.
    logic        sh_armed [NSLOT];
    logic [1:0]  sh_kind  [NSLOT];
    logic [31:0] sh_due   [NSLOT];
    logic [31:0] sh_period[NSLOT];
    logic [15:0] sh_left  [NSLOT];

    t_firing pending_firings[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_off_cycles = 0;
    int      quiet_cycles = 0;

    function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int earliest_due(logic [31:0] now);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
            if (sh_armed[i] && sh_due[i] <= now)
                if (best < 0 || sh_due[i] < sh_due[best]) best = i;
        return best;
    endfunction

    // Applies one beat to the shadow table and queues the firings it causes.
    task automatic predict_beat(logic func, logic [3:0] slot, logic [1:0] kind,
                                logic [31:0] st, logic [31:0] dl, logic [31:0] per,
                                logic [15:0] reps, logic [31:0] now);
        int n;
        int s;
        t_firing f;
        n = 0;
        if (func == FUNC_ARM) begin
            if (kind == KIND_INVALID) return;
            sh_kind[slot]   = kind;
            sh_due[slot]    = clamp_add(st, dl);
            sh_period[slot] = per;
            sh_left[slot]   = reps;
            sh_armed[slot]  = !(kind == KIND_REPEATED && reps == 16'd0);
            return;
        end
        while (n < FIRECAP) begin
            s = earliest_due(now);
            if (s < 0) break;
            f = '{fired_slot: s[3:0], due_time: sh_due[s], fire_time: now,
                  more_pending: 1'b0, last: 1'b0};
            pending_firings.push_back(f);
            n++;
            if (sh_kind[s] == KIND_ONESHOT) begin
                sh_armed[s] = 1'b0;
            end else if (sh_kind[s] == KIND_REPEATED) begin
                if (sh_left[s] <= 16'd1) begin
                    sh_left[s]  = 16'd0;
                    sh_armed[s] = 1'b0;
                end else begin
                    sh_left[s] = sh_left[s] - 16'd1;
                    sh_due[s]  = clamp_add(sh_due[s], sh_period[s]);
                end
            end else begin
                sh_due[s] = clamp_add(sh_due[s], sh_period[s]);
            end
        end
        if (n > 0) begin
            f = pending_firings.pop_back();
            f.last = 1'b1;
            f.more_pending = (n == FIRECAP) && (earliest_due(now) >= 0);
            pending_firings.push_back(f);
        end
    endtask

    // Offers one beat, with random idle cycles before it. Valid stays high
    // after the accepting edge; the next idle cycle or drain lowers it.
    task automatic send_beat(logic func, logic [3:0] slot, logic [1:0] kind,
                             logic [31:0] st, logic [31:0] dl, logic [31:0] per,
                             logic [15:0] reps, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= func;
        in_ch.slot         <= slot;
        in_ch.kind         <= kind;
        in_ch.start_time   <= st;
        in_ch.delay        <= dl;
        in_ch.period       <= per;
        in_ch.repeat_count <= reps;
        in_ch.now          <= now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_beat(func, slot, kind, st, dl, per, reps, now);
    endtask

    task automatic arm_slot(logic [3:0] slot, logic [1:0] kind, logic [31:0] st,
                            logic [31:0] dl, logic [31:0] per, logic [15:0] reps);
        send_beat(FUNC_ARM, slot, kind, st, dl, per, reps, $urandom);
    endtask

    task automatic tick_at(logic [31:0] now);
        send_beat(FUNC_TICK, 4'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
                  16'($urandom), now);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_firings.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Receiver: random stalls, an optional long hold-off, and the checker.
    always @(posedge i_clk) begin
        t_firing exp_f;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_firings.size() == 0) begin
                    $error("result with no firing expected: slot %0d", out_ch.fired_slot);
                    error_count++;
                end else begin
                    exp_f = pending_firings.pop_front();
                    if (out_ch.fired_slot !== exp_f.fired_slot) begin
                        $error("fired_slot expected %0d got %0d", exp_f.fired_slot,
                               out_ch.fired_slot);
                        error_count++;
                    end
                    if (out_ch.due_time !== exp_f.due_time) begin
                        $error("due_time expected %h got %h", exp_f.due_time,
                               out_ch.due_time);
                        error_count++;
                    end
                    if (out_ch.fire_time !== exp_f.fire_time) begin
                        $error("fire_time expected %h got %h", exp_f.fire_time,
                               out_ch.fire_time);
                        error_count++;
                    end
                    if (out_ch.more_pending !== exp_f.more_pending) begin
                        $error("more_pending expected %b got %b", exp_f.more_pending,
                               out_ch.more_pending);
                        error_count++;
                    end
                    if (out_ch.last !== exp_f.last) begin
                        $error("last expected %b got %b", exp_f.last, out_ch.last);
                        error_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("timed_event_scheduler_top test failed");
            $finish;
        end
    end

    // Edge values, every kind, and the special cases.
    task automatic test_directed();
        tick_at(32'hFFFF_FFFF);                                  // nothing armed
        arm_slot(4'd0, KIND_ONESHOT, 32'd10, 32'd5, 32'd1, 16'd0);
        arm_slot(4'd1, KIND_ONESHOT, 32'd5, 32'd10, 32'd1, 16'd0); // tie, higher slot
        arm_slot(4'd15, KIND_REPEATED, 32'd0, 32'd0, 32'd3, 16'd3);
        arm_slot(4'd2, KIND_REPEATED, 32'd0, 32'd1, 32'd1, 16'd0); // never fires
        arm_slot(4'd3, KIND_INTERVAL, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd1, 16'hFFFF);
        arm_slot(4'd3, KIND_INVALID, 32'd0, 32'd0, 32'd1, 16'd1); // ignored
        tick_at(32'd14);                                         // only slot 15 is due yet
        tick_at(32'd20);
        arm_slot(4'd4, KIND_INTERVAL, 32'd100, 32'd0, 32'd0, 16'd0); // zero period
        tick_at(32'd100);                                        // hits the cap
        tick_at(32'd100);
        arm_slot(4'd4, KIND_ONESHOT, 32'd0, 32'd0, 32'd1, 16'd0); // replace
        arm_slot(4'd5, KIND_REPEATED, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
        tick_at(32'hFFFF_FFFF);                                  // saturated due
        arm_slot(4'd3, KIND_ONESHOT, 32'd0, 32'd0, 32'd1, 16'd0);
        arm_slot(4'd5, KIND_ONESHOT, 32'd0, 32'd0, 32'd1, 16'd0);
        tick_at(32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Random arms and ticks on a moving clock, with noise from invalid kinds.
    task automatic test_random(int n_items);
        logic [31:0] clock_now;
        logic [1:0]  k;
        clock_now = $urandom_range(1000);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 60) begin
                k = ($urandom_range(19) == 0) ? KIND_INVALID : 2'($urandom_range(2));
                if ($urandom_range(9) == 0)
                    arm_slot(4'($urandom), k, $urandom, $urandom, $urandom,
                             16'($urandom));
                else
                    arm_slot(4'($urandom), k, clock_now, $urandom_range(200),
                             $urandom_range(1, 60), 16'($urandom_range(0, 6)));
            end else begin
                clock_now = clamp_add(clock_now, $urandom_range(120));
                tick_at(clock_now);
            end
        end
        // Retire the long-lived events before the next phase.
        for (int s = 0; s < NSLOT; s++)
            arm_slot(4'(s), KIND_ONESHOT, 32'd0, 32'd0, 32'd1, 16'd0);
        tick_at(32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Receiver holds off while ticks keep arriving, so the input stalls.
    task automatic test_backpressure();
        for (int s = 0; s < 8; s++)
            arm_slot(4'(s), KIND_REPEATED, 32'd0, s, 32'd1, 16'd4);
        hold_off_cycles <= 3000;
        for (int t = 0; t < 4; t++) tick_at(32'd2 + 2 * t);
        wait_drained();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_ARM;
        in_ch.slot = '0;
        in_ch.kind = KIND_ONESHOT;
        in_ch.start_time = '0;
        in_ch.delay = '0;
        in_ch.period = 32'd1;
        in_ch.repeat_count = '0;
        in_ch.now = '0;
        for (int i = 0; i < NSLOT; i++) begin
            sh_armed[i] = 1'b0;
            sh_kind[i]  = KIND_ONESHOT;
            sh_due[i]   = '0;
            sh_period[i] = '0;
            sh_left[i]  = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 30;
        recv_idle_pct = 73;
        test_directed();
        test_random(85);
        send_idle_pct = 73;
        recv_idle_pct = 30;
        test_backpressure();
        test_random(85);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(90);

        wait_drained();
        if (error_count == 0)
            $display("timed_event_scheduler_top test passed");
        else
            $display("timed_event_scheduler_top test failed");
        $finish;
    end
endmodule
